/* src/dtps_pkg.sv */
// Shared types and constants for the depth-tested pixel store.
package dtps_pkg;

  localparam int DIM_W   = 9;
  localparam int PAR_W   = 13;
  localparam int COORD_W = 16;
  localparam int DEPTH_W = 24;
  localparam int COLOR_W = 24;
  localparam int CHAN_W  = 8;
  localparam int MODE_W  = 3;
  localparam int STAT_W  = 3;
  localparam int LIN_W   = 2 * DIM_W + 1;
  localparam int AREA_W  = 2 * DIM_W;

  localparam logic [MODE_W-1:0] MODE_WRITE = 3'd0;
  localparam logic [MODE_W-1:0] MODE_TEST  = 3'd1;
  localparam logic [MODE_W-1:0] MODE_OVER  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_CLEAR = 3'd3;
  localparam logic [MODE_W-1:0] MODE_READ  = 3'd4;

  localparam logic [STAT_W-1:0] ST_WRITTEN    = 3'd0;
  localparam logic [STAT_W-1:0] ST_CLIPPED    = 3'd1;
  localparam logic [STAT_W-1:0] ST_DEPTH_FAIL = 3'd2;
  localparam logic [STAT_W-1:0] ST_READ       = 3'd3;
  localparam logic [STAT_W-1:0] ST_CLEAR      = 3'd4;

  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  localparam logic [DEPTH_W-1:0] DEPTH_FLOOR = 24'h800000;
  localparam logic [CHAN_W-1:0]  ALPHA       = 8'hFF;
  localparam logic [DIM_W-1:0]   DIM_RESET   = 9'd256;

  typedef struct packed {
    logic start;
    logic stop;
  } sweep_ctl_t;

  typedef struct packed {
    logic busy;
    logic wr;
    logic done;
  } sweep_stat_t;

  typedef enum logic [3:0] {
    S_SWEEP = 4'b0001,
    S_IDLE  = 4'b0010,
    S_ADDR  = 4'b0100,
    S_EVAL  = 4'b1000
  } state_t;

endpackage

/* src/dtps_ram.sv */
// Generic simple dual-port RAM with registered read.
module dtps_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 65536
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* src/dtps_sweep.sv */
// Sweep counter that fills a run of store entries, one per cycle.
module dtps_sweep #(
  parameter int DEPTH  = 65536,
  parameter int ADDR_W = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  dtps_pkg::sweep_ctl_t      ctl,
  input  logic [ADDR_W:0]           start_count,
  input  logic [dtps_pkg::CHAN_W-1:0] start_gray,
  output dtps_pkg::sweep_stat_t     stat,
  output logic [ADDR_W-1:0]         wr_addr,
  output logic [dtps_pkg::COLOR_W-1:0] wr_color
);

  logic                        busy;
  logic [ADDR_W:0]             cnt;
  logic [ADDR_W:0]             last;
  logic [dtps_pkg::CHAN_W-1:0] gray;

  // Power-up sweep covers the whole store with black; a start sweeps start_count entries with start_gray.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b1;
      cnt  <= '0;
      last <= (ADDR_W + 1)'(DEPTH);
      gray <= '0;
    end else if (ctl.start) begin
      busy <= 1'b1;
      cnt  <= '0;
      last <= start_count;
      gray <= start_gray;
    end else if (busy) begin
      if (cnt != last) begin
        cnt <= cnt + 1'b1;
      end else if (ctl.stop) begin
        busy <= 1'b0;
      end
    end
  end

  assign stat.busy = busy;
  assign stat.wr   = busy && (cnt != last);
  assign stat.done = busy && (cnt == last);
  assign wr_addr   = cnt[ADDR_W-1:0];
  assign wr_color  = {gray, gray, gray};

endmodule

/* src/depth_tested_pixel_store.sv */
// Top level of the depth-tested pixel store (color and depth frame memories).
//
// Usage:
//   Input beats (mode, x, y, depth_in, red, green, blue, gray) arrive on the
//   in_valid/in_ready channel; each produces exactly one result beat (status,
//   rgba_out, depth_out) on the out_valid/out_ready channel, in order.
//   Frame width and height are set through the cfg_write/cfg_index/cfg_data
//   port while the block is idle; values above the store size saturate.
//   Pixel modes pass each beat through an address cycle, then an evaluate
//   cycle: the address cycle computes y*width+x and issues the memory read,
//   the evaluate cycle sees the stored pixel, decides, writes back and loads
//   the result register; the next beat is taken as that cycle retires.
//   A clear sweeps width*height entries, one per cycle, and answers when it
//   ends and the result slot is free; no input is taken during the sweep.
//   Reset starts a clearing pass over all MAX_WIDTH*MAX_HEIGHT entries
//   (65536 at the default size) with in_ready low; config writes
//   are taken during it.
//   The result register holds a beat while out_ready is low; one more input
//   beat is taken meanwhile and waits in its evaluate cycle until the slot
//   frees.
module depth_tested_pixel_store #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  logic        clk,
  input  logic        rst,
  // configuration
  input  logic        cfg_write,
  input  logic        cfg_index,
  input  logic [8:0]  cfg_data,
  // input channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  mode,
  input  logic signed [15:0] x,
  input  logic signed [15:0] y,
  input  logic signed [23:0] depth_in,
  input  logic [7:0]  red,
  input  logic [7:0]  green,
  input  logic [7:0]  blue,
  input  logic [7:0]  gray,
  // output channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  status,
  output logic [31:0] rgba_out,
  output logic signed [23:0] depth_out
);

  localparam int STORE_SIZE = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W     = STORE_SIZE > 1 ? $clog2(STORE_SIZE) : 1;
  localparam logic [dtps_pkg::PAR_W-1:0] MAX_W_C = dtps_pkg::PAR_W'(MAX_WIDTH);
  localparam logic [dtps_pkg::PAR_W-1:0] MAX_H_C = dtps_pkg::PAR_W'(MAX_HEIGHT);

  dtps_pkg::state_t state;

  // configuration registers
  logic [dtps_pkg::DIM_W-1:0] frame_width;
  logic [dtps_pkg::DIM_W-1:0] frame_height;
  logic [dtps_pkg::DIM_W-1:0] act_w;
  logic [dtps_pkg::DIM_W-1:0] act_h;

  // captured item
  logic [dtps_pkg::MODE_W-1:0]        item_mode;
  logic signed [dtps_pkg::COORD_W-1:0] item_x;
  logic signed [dtps_pkg::COORD_W-1:0] item_y;
  logic signed [dtps_pkg::DEPTH_W-1:0] item_z;
  logic [dtps_pkg::COLOR_W-1:0]       item_color;
  logic [dtps_pkg::CHAN_W-1:0]        item_gray;

  // address stage
  logic                        in_frame;
  logic [dtps_pkg::LIN_W-1:0]  lin;
  logic [ADDR_W-1:0]           rd_addr;
  logic [ADDR_W-1:0]           addr_q;
  logic                        in_frame_q;
  logic [dtps_pkg::AREA_W-1:0] area;

  // memory side
  logic [dtps_pkg::COLOR_W-1:0] rd_color;
  logic [dtps_pkg::DEPTH_W-1:0] rd_depth;
  logic                         color_we;
  logic                         depth_we;
  logic [ADDR_W-1:0]            wr_addr;
  logic [dtps_pkg::COLOR_W-1:0] wr_color;
  logic [dtps_pkg::DEPTH_W-1:0] wr_depth;

  // evaluate stage
  logic                         ev_color_we;
  logic                         ev_depth_we;
  logic [dtps_pkg::STAT_W-1:0]  ev_status;
  logic [31:0]                  ev_rgba;
  logic [dtps_pkg::DEPTH_W-1:0] ev_depth;
  logic                         z_ok;
  logic                         z_nearer;

  // sweep engine
  dtps_pkg::sweep_ctl_t         sweep_ctl;
  dtps_pkg::sweep_stat_t        sweep_stat;
  logic [ADDR_W-1:0]            sweep_addr;
  logic [dtps_pkg::COLOR_W-1:0] sweep_color;
  logic                         report;

  logic slot_free;
  logic accept;
  logic finish_eval;
  logic finish_sweep;

  // Saturate the frame size to what the store holds.
  assign act_w = ({4'b0, frame_width} > MAX_W_C) ? MAX_W_C[dtps_pkg::DIM_W-1:0] : frame_width;
  assign act_h = ({4'b0, frame_height} > MAX_H_C) ? MAX_H_C[dtps_pkg::DIM_W-1:0] : frame_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= dtps_pkg::DIM_RESET;
      frame_height <= dtps_pkg::DIM_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        dtps_pkg::REG_WIDTH:  frame_width  <= cfg_data;
        dtps_pkg::REG_HEIGHT: frame_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // Handshake: take a beat when idle, or when the evaluate cycle retires.
  assign slot_free    = !out_valid || out_ready;
  assign finish_eval  = (state == dtps_pkg::S_EVAL) && slot_free;
  assign finish_sweep = (state == dtps_pkg::S_SWEEP) && sweep_stat.done &&
                        (!report || slot_free);
  assign in_ready     = (state == dtps_pkg::S_IDLE) || finish_eval;
  assign accept       = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (accept) begin
      item_mode  <= mode;
      item_x     <= x;
      item_y     <= y;
      item_z     <= depth_in;
      item_color <= {red, green, blue};
      item_gray  <= gray;
    end
  end

  // Clip and linear address; y and x fit the frame size bits once inside.
  assign in_frame = !item_x[dtps_pkg::COORD_W-1] && !item_y[dtps_pkg::COORD_W-1] &&
                    (item_x[dtps_pkg::COORD_W-2:0] < (dtps_pkg::COORD_W - 1)'(act_w)) &&
                    (item_y[dtps_pkg::COORD_W-2:0] < (dtps_pkg::COORD_W - 1)'(act_h));
  assign lin = dtps_pkg::LIN_W'(item_y[dtps_pkg::DIM_W-1:0]) * dtps_pkg::LIN_W'(act_w) +
               dtps_pkg::LIN_W'(item_x[dtps_pkg::DIM_W-1:0]);
  assign rd_addr = ADDR_W'(lin);
  assign area    = dtps_pkg::AREA_W'(act_w) * dtps_pkg::AREA_W'(act_h);

  always_ff @(posedge clk) begin
    if (state == dtps_pkg::S_ADDR) begin
      addr_q     <= rd_addr;
      in_frame_q <= in_frame;
    end
  end

  // Kick off a clear sweep from the address cycle of a clear beat.
  always_comb begin
    sweep_ctl.start = (state == dtps_pkg::S_ADDR) && (item_mode == dtps_pkg::MODE_CLEAR);
    sweep_ctl.stop  = finish_sweep;
  end

  dtps_sweep #(
    .DEPTH (STORE_SIZE),
    .ADDR_W(ADDR_W)
  ) u_sweep (
    .clk        (clk),
    .rst        (rst),
    .ctl        (sweep_ctl),
    .start_count((ADDR_W + 1)'(area)),
    .start_gray (item_gray),
    .stat       (sweep_stat),
    .wr_addr    (sweep_addr),
    .wr_color   (sweep_color)
  );

  // Decide the pixel beat from the stored entry.
  assign z_ok     = item_z[dtps_pkg::DEPTH_W-1] || (item_z == '0);
  assign z_nearer = item_z > $signed(rd_depth);

  always_comb begin
    ev_color_we = 1'b0;
    ev_depth_we = 1'b0;
    ev_status   = dtps_pkg::ST_CLIPPED;
    ev_rgba     = '0;
    ev_depth    = '0;
    if (in_frame_q) begin
      case (item_mode)
        dtps_pkg::MODE_WRITE: begin
          ev_color_we = 1'b1;
          ev_status   = dtps_pkg::ST_WRITTEN;
        end
        dtps_pkg::MODE_TEST: begin
          if (z_ok && z_nearer) begin
            ev_color_we = 1'b1;
            ev_depth_we = 1'b1;
            ev_status   = dtps_pkg::ST_WRITTEN;
          end else begin
            ev_status = dtps_pkg::ST_DEPTH_FAIL;
          end
        end
        dtps_pkg::MODE_OVER: begin
          if (z_ok) begin
            ev_color_we = 1'b1;
            ev_depth_we = 1'b1;
            ev_status   = dtps_pkg::ST_WRITTEN;
          end else begin
            ev_status = dtps_pkg::ST_DEPTH_FAIL;
          end
        end
        dtps_pkg::MODE_READ: begin
          ev_status = dtps_pkg::ST_READ;
          ev_rgba   = {rd_color, dtps_pkg::ALPHA};
          ev_depth  = rd_depth;
        end
        default: ;
      endcase
    end
  end

  // Write port: the sweep owns it while running, else the evaluate cycle.
  always_comb begin
    if (sweep_stat.busy) begin
      color_we = sweep_stat.wr;
      depth_we = sweep_stat.wr;
      wr_addr  = sweep_addr;
      wr_color = sweep_color;
      wr_depth = dtps_pkg::DEPTH_FLOOR;
    end else begin
      color_we = finish_eval && ev_color_we;
      depth_we = finish_eval && ev_depth_we;
      wr_addr  = addr_q;
      wr_color = item_color;
      wr_depth = item_z;
    end
  end

  dtps_ram #(
    .WIDTH(dtps_pkg::COLOR_W),
    .DEPTH(STORE_SIZE)
  ) u_color_ram (
    .clk  (clk),
    .we   (color_we),
    .waddr(wr_addr),
    .wdata(wr_color),
    .raddr(rd_addr),
    .rdata(rd_color)
  );

  dtps_ram #(
    .WIDTH(dtps_pkg::DEPTH_W),
    .DEPTH(STORE_SIZE)
  ) u_depth_ram (
    .clk  (clk),
    .we   (depth_we),
    .waddr(wr_addr),
    .wdata(wr_depth),
    .raddr(rd_addr),
    .rdata(rd_depth)
  );

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= dtps_pkg::S_SWEEP;
      report <= 1'b0;
    end else begin
      case (state)
        dtps_pkg::S_SWEEP: begin
          if (finish_sweep) begin
            state <= dtps_pkg::S_IDLE;
          end
        end
        dtps_pkg::S_IDLE: begin
          if (accept) begin
            state <= dtps_pkg::S_ADDR;
          end
        end
        dtps_pkg::S_ADDR: begin
          if (item_mode == dtps_pkg::MODE_CLEAR) begin
            state  <= dtps_pkg::S_SWEEP;
            report <= 1'b1;
          end else begin
            state <= dtps_pkg::S_EVAL;
          end
        end
        dtps_pkg::S_EVAL: begin
          if (finish_eval) begin
            state <= accept ? dtps_pkg::S_ADDR : dtps_pkg::S_IDLE;
          end
        end
        default: state <= dtps_pkg::S_IDLE;
      endcase
    end
  end

  // Result register: load on retire, drop the beat once taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (finish_eval || (finish_sweep && report)) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish_eval) begin
      status    <= ev_status;
      rgba_out  <= ev_rgba;
      depth_out <= ev_depth;
    end else if (finish_sweep && report) begin
      status    <= dtps_pkg::ST_CLEAR;
      rgba_out  <= '0;
      depth_out <= '0;
    end
  end

`ifndef SYNTHESIS
  a_no_accept_in_sweep: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !sweep_stat.busy)
    else $error("input taken while a sweep runs");

  a_eval_write_exclusive: assert property (@(posedge clk) disable iff (rst)
    (finish_eval && (ev_color_we || ev_depth_we)) |-> !sweep_stat.busy)
    else $error("pixel write collides with sweep");

  a_accept_to_addr: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == dtps_pkg::S_ADDR))
    else $error("accepted beat did not enter the address cycle");
`endif

endmodule

/* tb/sv/depth_tested_pixel_store_tb.sv */
// Self-checking testbench for the depth-tested pixel store: handshake driver, monitor, frame predictor.
module depth_tested_pixel_store_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Size of the frame memories in the block (default parameters).
  localparam int MAX_W       = 256;
  localparam int MAX_H       = 256;
  localparam int STORE_SIZE  = MAX_W * MAX_H;
  localparam int IDX_W       = $clog2(STORE_SIZE);
  // Slowest run: reset sweep, one full-size clear, ~1800 beats with long
  // gaps and stalls, small clears. CYCLE_LIMIT leaves a wide margin.
  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int ITEMS_PER_PHASE = 250;

  // Mode codes that the block does not use.
  localparam logic [dtps_pkg::MODE_W-1:0] MODE_SPARE_FIRST = 3'd5;
  localparam logic [dtps_pkg::MODE_W-1:0] MODE_SPARE_LAST  = 3'd7;

  // One input beat as the predictor sees it.
  typedef struct {
    logic [dtps_pkg::MODE_W-1:0]         op;
    logic signed [dtps_pkg::COORD_W-1:0] px;
    logic signed [dtps_pkg::COORD_W-1:0] py;
    logic signed [dtps_pkg::DEPTH_W-1:0] pz;
    logic [dtps_pkg::CHAN_W-1:0]         r;
    logic [dtps_pkg::CHAN_W-1:0]         g;
    logic [dtps_pkg::CHAN_W-1:0]         b;
    logic [dtps_pkg::CHAN_W-1:0]         level;
  } fragment_t;

  // One result beat.
  typedef struct {
    logic [dtps_pkg::STAT_W-1:0]         code;
    logic [31:0]                         rgba;
    logic signed [dtps_pkg::DEPTH_W-1:0] zval;
  } outcome_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                      cfg_write = 1'b0;
  logic                      cfg_index = dtps_pkg::REG_WIDTH;
  logic [8:0]                cfg_data  = '0;

  logic                      in_valid  = 1'b0;
  logic                      in_ready;
  logic [2:0]                mode      = dtps_pkg::MODE_READ;
  logic signed [15:0]        x         = '0;
  logic signed [15:0]        y         = '0;
  logic signed [23:0]        depth_in  = '0;
  logic [7:0]                red       = '0;
  logic [7:0]                green     = '0;
  logic [7:0]                blue      = '0;
  logic [7:0]                gray      = '0;

  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic [2:0]                status;
  logic [31:0]               rgba_out;
  logic signed [23:0]        depth_out;

  depth_tested_pixel_store dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .mode      (mode),
    .x         (x),
    .y         (y),
    .depth_in  (depth_in),
    .red       (red),
    .green     (green),
    .blue      (blue),
    .gray      (gray),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .rgba_out  (rgba_out),
    .depth_out (depth_out)
  );

  always #1 clk = ~clk;

  // ---------------------------------------------------------------------
  // Frame predictor: its own copy of both memories and both registers.
  // ---------------------------------------------------------------------
  logic [dtps_pkg::COLOR_W-1:0]        color_mem [0:STORE_SIZE-1];
  logic signed [dtps_pkg::DEPTH_W-1:0] depth_mem [0:STORE_SIZE-1];
  logic [dtps_pkg::DIM_W-1:0]          frame_w = dtps_pkg::DIM_RESET;
  logic [dtps_pkg::DIM_W-1:0]          frame_h = dtps_pkg::DIM_RESET;

  fragment_t fragment_queue[$];   // beats waiting for the driver
  outcome_t  pending_outcomes[$]; // predicted results, oldest first
  fragment_t cur_fragment;
  outcome_t  expected_outcome;

  int fragments_queued   = 0;
  int fragments_accepted = 0;
  int results_seen       = 0;
  int clears_predicted   = 0;
  int settings_used      = 0;
  int error_count        = 0;
  int cycle_count        = 0;

  // Registers above the store size act as the store size.
  function automatic int active_width();
    return (frame_w > MAX_W) ? MAX_W : int'(frame_w);
  endfunction

  function automatic int active_height();
    return (frame_h > MAX_H) ? MAX_H : int'(frame_h);
  endfunction

  // Apply one accepted beat to the frame copy and return its result.
  function automatic outcome_t predict_pixel_outcome(fragment_t f);
    outcome_t o;
    int aw, ah, ix, iy, idx, i;
    bit on_frame;
    aw = active_width();
    ah = active_height();
    ix = int'(f.px);
    iy = int'(f.py);
    o.code = dtps_pkg::ST_CLIPPED;
    o.rgba = '0;
    o.zval = '0;
    // clip first, depth afterwards
    on_frame = ix >= 0 && iy >= 0 && ix < aw && iy < ah;
    idx = on_frame ? iy * aw + ix : 0;
    if (f.op == dtps_pkg::MODE_CLEAR) begin
      // only the active frame is swept; entries past it keep their contents
      for (i = 0; i < aw * ah; i++) begin
        color_mem[IDX_W'(i)] = {f.level, f.level, f.level};
        depth_mem[IDX_W'(i)] = dtps_pkg::DEPTH_FLOOR;
      end
      o.code = dtps_pkg::ST_CLEAR;
      clears_predicted++;
    end else if (on_frame) begin
      case (f.op)
        dtps_pkg::MODE_WRITE: begin
          color_mem[IDX_W'(idx)] = {f.r, f.g, f.b};
          o.code = dtps_pkg::ST_WRITTEN;
        end
        dtps_pkg::MODE_TEST: begin
          // nearer is larger; positive depth never passes
          if (f.pz <= 0 && f.pz > depth_mem[IDX_W'(idx)]) begin
            depth_mem[IDX_W'(idx)] = f.pz;
            color_mem[IDX_W'(idx)] = {f.r, f.g, f.b};
            o.code = dtps_pkg::ST_WRITTEN;
          end else begin
            o.code = dtps_pkg::ST_DEPTH_FAIL;
          end
        end
        dtps_pkg::MODE_OVER: begin
          if (f.pz <= 0) begin
            depth_mem[IDX_W'(idx)] = f.pz;
            color_mem[IDX_W'(idx)] = {f.r, f.g, f.b};
            o.code = dtps_pkg::ST_WRITTEN;
          end else begin
            o.code = dtps_pkg::ST_DEPTH_FAIL;
          end
        end
        dtps_pkg::MODE_READ: begin
          o.rgba = {color_mem[IDX_W'(idx)], dtps_pkg::ALPHA};
          o.zval = depth_mem[IDX_W'(idx)];
          o.code = dtps_pkg::ST_READ;
        end
        default: begin
          // unused modes answer clipped and touch nothing
        end
      endcase
    end
    return o;
  endfunction

  // ---------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------
  task automatic queue_fragment(input logic [dtps_pkg::MODE_W-1:0] op, input int px,
                                input int py, input int pz, input logic [7:0] r,
                                input logic [7:0] g, input logic [7:0] b,
                                input logic [7:0] level);
    fragment_t f;
    f.op    = op;
    f.px    = dtps_pkg::COORD_W'(px);
    f.py    = dtps_pkg::COORD_W'(py);
    f.pz    = dtps_pkg::DEPTH_W'(pz);
    f.r     = r;
    f.g     = g;
    f.b     = b;
    f.level = level;
    fragment_queue.push_back(f);
    fragments_queued++;
  endtask

  // Random beat aimed mostly inside the active frame so that depth tests
  // meet pixels that were written before.
  function automatic fragment_t random_fragment();
    fragment_t f;
    int aw, ah, pick, zneg;
    aw = active_width();
    ah = active_height();
    pick = $urandom_range(0, 99);
    if (pick < 2)       f.op = dtps_pkg::MODE_CLEAR;
    else if (pick < 5)  f.op = dtps_pkg::MODE_W'($urandom_range(MODE_SPARE_FIRST,
                                                                MODE_SPARE_LAST));
    else if (pick < 20) f.op = dtps_pkg::MODE_WRITE;
    else if (pick < 50) f.op = dtps_pkg::MODE_TEST;
    else if (pick < 62) f.op = dtps_pkg::MODE_OVER;
    else                f.op = dtps_pkg::MODE_READ;

    pick = $urandom_range(0, 9);
    if (pick == 0 || aw == 0 || ah == 0) begin
      f.px = dtps_pkg::COORD_W'($urandom);
      f.py = dtps_pkg::COORD_W'($urandom);
    end else if (pick == 1) begin
      // just off one border
      f.px = dtps_pkg::COORD_W'($urandom_range(0, aw - 1));
      f.py = dtps_pkg::COORD_W'($urandom_range(0, ah - 1));
      case ($urandom_range(0, 3))
        0: f.px = dtps_pkg::COORD_W'(-1);
        1: f.px = dtps_pkg::COORD_W'(aw);
        2: f.py = dtps_pkg::COORD_W'(-1);
        default: f.py = dtps_pkg::COORD_W'(ah);
      endcase
    end else begin
      f.px = dtps_pkg::COORD_W'($urandom_range(0, aw - 1));
      f.py = dtps_pkg::COORD_W'($urandom_range(0, ah - 1));
    end

    pick = $urandom_range(0, 9);
    zneg = $urandom_range(0, 200);
    case (pick)
      0: f.pz = '0;
      1: f.pz = dtps_pkg::DEPTH_W'($urandom_range(1, 8388607));
      2: f.pz = dtps_pkg::DEPTH_FLOOR;
      3: f.pz = dtps_pkg::DEPTH_W'($urandom);
      default: f.pz = dtps_pkg::DEPTH_W'(-zneg);
    endcase

    f.r     = dtps_pkg::CHAN_W'($urandom);
    f.g     = dtps_pkg::CHAN_W'($urandom);
    f.b     = dtps_pkg::CHAN_W'($urandom);
    f.level = dtps_pkg::CHAN_W'($urandom);
    return f;
  endfunction

  // Idle means every queued beat has produced its result.
  task automatic wait_frame_idle();
    do @(posedge clk); while (results_seen != fragments_queued);
  endtask

  // Write both frame registers; only called while idle.
  task automatic set_frame(input logic [dtps_pkg::DIM_W-1:0] w,
                           input logic [dtps_pkg::DIM_W-1:0] h);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= dtps_pkg::REG_WIDTH;
    cfg_data  <= w;
    @(posedge clk);
    cfg_index <= dtps_pkg::REG_HEIGHT;
    cfg_data  <= h;
    @(posedge clk);
    cfg_write <= 1'b0;
    frame_w = w;
    frame_h = h;
    settings_used++;
  endtask

  // ---------------------------------------------------------------------
  // Driver: bursts of beats from the queue separated by random gaps.
  // Valid is only ever lowered after a beat is taken.
  // ---------------------------------------------------------------------
  int burst_left = 1;
  int gap_left   = 0;

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      // the beat held during the last cycle was taken: predict it now
      if (in_valid && in_ready) begin
        pending_outcomes.push_back(predict_pixel_outcome(cur_fragment));
        fragments_accepted++;
      end
      if (!in_valid || in_ready) begin
        if (gap_left > 0 || fragment_queue.size() == 0) begin
          if (gap_left > 0) gap_left--;
          in_valid <= 1'b0;
        end else begin
          cur_fragment = fragment_queue.pop_front();
          mode     <= cur_fragment.op;
          x        <= cur_fragment.px;
          y        <= cur_fragment.py;
          depth_in <= cur_fragment.pz;
          red      <= cur_fragment.r;
          green    <= cur_fragment.g;
          blue     <= cur_fragment.b;
          gray     <= cur_fragment.level;
          in_valid <= 1'b1;
          if (burst_left <= 1) begin
            // end of burst: pick the next one; many gaps are zero so
            // long back-to-back stretches occur as well
            burst_left = $urandom_range(1, 30);
            gap_left   = ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 15);
          end else begin
            burst_left--;
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Receiver: out_ready follows a rotating 16-bit pattern that is swapped
  // whenever rx_count wraps (always ready, random, one long stall, or a comb).
  // ---------------------------------------------------------------------
  logic [15:0] rx_pattern = 16'hFFFF;
  logic [5:0]  rx_count   = '0;

  always @(posedge clk) begin
    rx_count <= rx_count + 1'b1;
    if (rx_count == 0) begin
      case ($urandom_range(0, 3))
        0: rx_pattern <= 16'hFFFF;
        1: rx_pattern <= 16'($urandom);
        2: rx_pattern <= 16'h8000;
        default: rx_pattern <= 16'hB6DB;
      endcase
    end else begin
      rx_pattern <= {rx_pattern[0], rx_pattern[15:1]};
    end
    out_ready <= rx_pattern[0];
  end

  // ---------------------------------------------------------------------
  // Monitor: match every result beat against the oldest prediction.
  // ---------------------------------------------------------------------
  task automatic flag_error(input string what, input logic [31:0] want,
                            input logic [31:0] got);
    error_count++;
    $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, what, want, got);
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending_outcomes.size() == 0) begin
        error_count++;
        $display("%0t: result beat with nothing expected, got status %0d", $time, status);
      end else begin
        expected_outcome = pending_outcomes.pop_front();
        if (status !== expected_outcome.code)
          flag_error("status", 32'(expected_outcome.code), 32'(status));
        if (rgba_out !== expected_outcome.rgba)
          flag_error("rgba_out", expected_outcome.rgba, rgba_out);
        if (depth_out !== expected_outcome.zval)
          flag_error("depth_out", {8'h00, expected_outcome.zval}, {8'h00, depth_out});
        results_seen++;
      end
    end
  end

  // Hard stop if the block hangs.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------
  int plan_w [7] = '{1, 16, 7, 256, 2, 12, 300};
  int plan_h [7] = '{1, 16, 33, 3, 256, 5, 2};

  initial begin
    // frame copy starts the way reset leaves the block: black, depth at floor
    for (int i = 0; i < STORE_SIZE; i++) begin
      color_mem[IDX_W'(i)] = '0;
      depth_mem[IDX_W'(i)] = dtps_pkg::DEPTH_FLOOR;
    end
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed part at the reset size 256 x 256. Beats wait out the
    // clearing pass that follows reset.
    queue_fragment(dtps_pkg::MODE_READ,  0,   0,   0,        8'h00, 8'h00, 8'h00, 8'h00);
    queue_fragment(dtps_pkg::MODE_TEST,  0,   0,   0,        8'hFF, 8'h00, 8'h80, 8'h00);
    // equal depth fails, positive depth fails
    queue_fragment(dtps_pkg::MODE_TEST,  0,   0,   0,        8'h12, 8'h34, 8'h56, 8'h00);
    queue_fragment(dtps_pkg::MODE_TEST,  0,   0,   1,        8'h12, 8'h34, 8'h56, 8'h00);
    queue_fragment(dtps_pkg::MODE_OVER,  255, 255, -8388608, 8'h01, 8'h02, 8'h03, 8'h00);
    queue_fragment(dtps_pkg::MODE_WRITE, 255, 0,   8388607,  8'hFF, 8'hFF, 8'hFF, 8'h00);
    queue_fragment(dtps_pkg::MODE_OVER,  1,   0,   5,        8'h77, 8'h77, 8'h77, 8'h00);
    queue_fragment(dtps_pkg::MODE_READ,  255, 255, 0,        8'h00, 8'h00, 8'h00, 8'h00);
    queue_fragment(dtps_pkg::MODE_READ,  255, 0,   0,        8'h00, 8'h00, 8'h00, 8'h00);
    // just past the right edge, left of the frame, below it, far away
    queue_fragment(dtps_pkg::MODE_WRITE, 256, 0,   0,        8'hAA, 8'hAA, 8'hAA, 8'h00);
    queue_fragment(dtps_pkg::MODE_TEST,  -1,  0,   -5,       8'hAA, 8'hAA, 8'hAA, 8'h00);
    queue_fragment(dtps_pkg::MODE_READ,  0,   256, 0,        8'h00, 8'h00, 8'h00, 8'h00);
    queue_fragment(dtps_pkg::MODE_WRITE, -32768, 32767, 0,   8'hAA, 8'hAA, 8'hAA, 8'h00);
    // unused modes
    queue_fragment(MODE_SPARE_FIRST,     0,   0,   0,        8'h00, 8'h00, 8'h00, 8'h00);
    queue_fragment(MODE_SPARE_LAST,      3,   3,   -1,       8'hFF, 8'hFF, 8'hFF, 8'hFF);
    queue_fragment(dtps_pkg::MODE_READ,  0,   0,   0,        8'h00, 8'h00, 8'h00, 8'h00);
    queue_fragment(dtps_pkg::MODE_TEST,  1,   1,   -8388608, 8'h55, 8'h55, 8'h55, 8'h00);
    // full frame clear
    queue_fragment(dtps_pkg::MODE_CLEAR, 0,   0,   0,        8'h00, 8'h00, 8'h00, 8'hA5);
    queue_fragment(dtps_pkg::MODE_READ,  255, 255, 0,        8'h00, 8'h00, 8'h00, 8'h00);

    // Zero width: every access clips and a clear touches nothing.
    wait_frame_idle();
    set_frame(9'd0, 9'd7);
    queue_fragment(dtps_pkg::MODE_WRITE, 0, 0, 0, 8'hCC, 8'hCC, 8'hCC, 8'h00);
    queue_fragment(dtps_pkg::MODE_CLEAR, 0, 0, 0, 8'h00, 8'h00, 8'h00, 8'h11);

    // Oversized width saturates to the store width.
    wait_frame_idle();
    set_frame(9'd511, 9'd2);
    queue_fragment(dtps_pkg::MODE_READ,  0,   0, 0,  8'h00, 8'h00, 8'h00, 8'h00);
    queue_fragment(dtps_pkg::MODE_OVER,  255, 1, -1, 8'h9A, 8'hBC, 8'hDE, 8'h00);
    queue_fragment(dtps_pkg::MODE_READ,  255, 1, 0,  8'h00, 8'h00, 8'h00, 8'h00);
    queue_fragment(dtps_pkg::MODE_WRITE, 0,   2, 0,  8'h44, 8'h44, 8'h44, 8'h00);
    queue_fragment(dtps_pkg::MODE_CLEAR, 0,   0, 0,  8'h00, 8'h00, 8'h00, 8'hFF);
    queue_fragment(dtps_pkg::MODE_READ,  5,   0, 0,  8'h00, 8'h00, 8'h00, 8'h00);

    // Random part: mostly small frames so that clears stay short and
    // pixels get hit again and again.
    for (int p = 0; p < 7; p++) begin
      wait_frame_idle();
      set_frame(dtps_pkg::DIM_W'(plan_w[p]), dtps_pkg::DIM_W'(plan_h[p]));
      repeat (ITEMS_PER_PHASE) begin
        fragment_queue.push_back(random_fragment());
        fragments_queued++;
      end
    end

    // Drain, then hold a little longer to catch stray result beats.
    wait_frame_idle();
    repeat (20) @(posedge clk);

    $display("Pixel store run: %0d beats taken, %0d results checked, %0d clears.",
             fragments_accepted, results_seen, clears_predicted);
    $display("Frame sizes used: %0d, including zero, saturated and full size; %0d errors.",
             settings_used + 1, error_count);
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

/* filelist.f */
src/dtps_pkg.sv
src/dtps_ram.sv
src/dtps_sweep.sv
src/depth_tested_pixel_store.sv
tb/sv/depth_tested_pixel_store_tb.sv
